/* hw/rtl/dphd_pkg.sv */
`default_nettype none
package dphd_pkg;

   // sizes that follow from the stream fields
   localparam int SAMPLE_BITS    = 12;
   localparam int COUNT_BITS     = 16;
   localparam int FIELD_SAMPLE_W = 12;
   localparam int TIME_W         = 32;
   localparam int DUR_W          = 16;
   localparam int OUT_COUNT_W    = 16;
   localparam int NUM_PADS       = 4;
   localparam int PAD_IDX_W      = 2;
   localparam int REQ_W          = NUM_PADS * FIELD_SAMPLE_W + TIME_W;
   localparam int RSP_FIELDS_W   = NUM_PADS + 2 * OUT_COUNT_W;
   localparam int RSP_W          = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int RISE_W         = ((SAMPLE_BITS > DUR_W) ? SAMPLE_BITS : DUR_W) + 1;
   localparam int EDGE_CNT_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KEY_TIMEOUT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DON_DEBOUNCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KA_DEBOUNCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CROSSTALK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_TIMEOUT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLDS   = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_DEB,
      ST_XTALK,
      ST_CHG,
      ST_ROLL,
      ST_EDGE
   } dphd_state_type;

endpackage
`default_nettype wire

/* hw/rtl/drum_pad_hit_detector.sv */
// each accepted req word is scanned pad by pad: key, debounce, crosstalk and last-change
// steps on the shared 32-bit add/compare unit, ending early when a check fails, then one roll
// and one edge step; the edge step also waits while the previous rsp word is still held
// a new req word is taken only after the scan ends; req_tready is high only while idle
// reset: synchronous, active high; clears all pad timers, roll counters, configuration registers
// and any word in flight, after which the block is ready on the next cycle
`default_nettype none
module drum_pad_hit_detector import dphd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // left don sample, right don sample, left ka sample, right ka sample, now_ms
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // left don hit, right don hit, left ka hit, right ka hit, roll_count,
   // last_roll_count, zero fill
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [COUNT_BITS:0] COUNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

   dphd_state_type state_ff, state_in;
   logic [PAD_IDX_W-1:0] pad_ff, pad_in;

   logic [DUR_W-1:0]  key_ff, don_deb_ff, ka_deb_ff, xtalk_ff;
   logic [TIME_W-1:0] roll_to_ff;
   logic [4*DUR_W-1:0] thr_ff;

   logic [SAMPLE_BITS-1:0] sample_ff [NUM_PADS];
   logic [TIME_W-1:0]      now_ff;

   logic [SAMPLE_BITS-1:0] prev_ff [NUM_PADS];
   logic [SAMPLE_BITS-1:0] prev_in [NUM_PADS];
   logic [NUM_PADS-1:0]    active_ff, active_in;
   logic [TIME_W-1:0]      trig_ff [NUM_PADS];
   logic [TIME_W-1:0]      trig_in [NUM_PADS];
   logic [TIME_W-1:0]      change_ff [NUM_PADS];
   logic [TIME_W-1:0]      change_in [NUM_PADS];
   logic [TIME_W-1:0]      don_hit_ff, don_hit_in, ka_hit_ff, ka_hit_in;
   logic [TIME_W-1:0]      roll_hit_ff, roll_hit_in;
   logic [COUNT_BITS-1:0]  running_ff, running_in, roll_prev_ff, roll_prev_in;
   logic [NUM_PADS-1:0]    prev_hits_ff, prev_hits_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   // shared add/subtract and magnitude compare unit
   logic [TIME_W-1:0] unit_a, unit_b, unit_lim, unit_res;
   logic              unit_sub, unit_gt, unit_eq;

   logic                  is_don;
   logic signed [RISE_W-1:0] rise;
   logic signed [RISE_W-1:0] thr_s;
   logic                  rise_ok;
   logic [NUM_PADS-1:0]   new_edges;
   logic [EDGE_CNT_W-1:0] edge_cnt;
   logic [COUNT_BITS:0]   count_sum;
   logic [COUNT_BITS-1:0] count_next;

   assign unit_res = unit_sub ? (unit_a - unit_b) : (unit_a + unit_b);
   assign unit_gt  = unit_res > unit_lim;
   assign unit_eq  = unit_res == unit_lim;

   assign is_don  = (pad_ff < PAD_IDX_W'(NUM_PADS / 2));
   assign rise    = $signed(RISE_W'(sample_ff[pad_ff])) - $signed(RISE_W'(prev_ff[pad_ff]));
   assign thr_s   = $signed(RISE_W'(thr_ff[pad_ff*DUR_W +: DUR_W]));
   assign rise_ok = rise > thr_s;

   assign new_edges = active_ff & ~prev_hits_ff;
   always_comb begin
      edge_cnt = '0;
      for (int i = 0; i < NUM_PADS; i++) begin
         edge_cnt = edge_cnt + EDGE_CNT_W'(new_edges[i]);
      end
   end
   assign count_sum  = {1'b0, running_ff} + (COUNT_BITS+1)'(edge_cnt);
   assign count_next = (count_sum > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                               : count_sum[COUNT_BITS-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      pad_in       = pad_ff;
      prev_in      = prev_ff;
      active_in    = active_ff;
      trig_in      = trig_ff;
      change_in    = change_ff;
      don_hit_in   = don_hit_ff;
      ka_hit_in    = ka_hit_ff;
      roll_hit_in  = roll_hit_ff;
      running_in   = running_ff;
      roll_prev_in = roll_prev_ff;
      prev_hits_in = prev_hits_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unit_a       = now_ff;
      unit_b       = trig_ff[pad_ff];
      unit_lim     = TIME_W'(key_ff);
      unit_sub     = 1'b1;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_KEY;
               pad_in   = '0;
            end
         end
         ST_KEY: begin
            // own key timeout; the same test releases an active pad
            prev_in[pad_ff] = sample_ff[pad_ff];
            if (active_ff[pad_ff] && unit_gt) begin
               active_in[pad_ff] = 1'b0;
               change_in[pad_ff] = now_ff;
            end
            if (unit_gt && rise_ok && !active_ff[pad_ff]) begin
               state_in = ST_DEB;
            end else if (unit_gt && rise_ok) begin
               state_in = ST_DEB;
            end else if (pad_ff == PAD_IDX_W'(NUM_PADS - 1)) begin
               state_in = ST_ROLL;
            end else begin
               pad_in = pad_ff + PAD_IDX_W'(1);
            end
         end
         ST_DEB: begin
            unit_b   = is_don ? don_hit_ff : ka_hit_ff;
            unit_lim = TIME_W'(is_don ? don_deb_ff : ka_deb_ff);
            if (!unit_gt && !unit_eq) begin
               if (pad_ff == PAD_IDX_W'(NUM_PADS - 1)) begin
                  state_in = ST_ROLL;
               end else begin
                  state_in = ST_KEY;
                  pad_in   = pad_ff + PAD_IDX_W'(1);
               end
            end else begin
               state_in = ST_XTALK;
            end
         end
         ST_XTALK: begin
            unit_b   = is_don ? ka_hit_ff : don_hit_ff;
            unit_lim = TIME_W'(xtalk_ff);
            if (!unit_gt) begin
               if (pad_ff == PAD_IDX_W'(NUM_PADS - 1)) begin
                  state_in = ST_ROLL;
               end else begin
                  state_in = ST_KEY;
                  pad_in   = pad_ff + PAD_IDX_W'(1);
               end
            end else begin
               state_in = ST_CHG;
            end
         end
         ST_CHG: begin
            // last change plus key timeout must not lie after now
            unit_a   = change_ff[pad_ff];
            unit_b   = TIME_W'(key_ff);
            unit_sub = 1'b0;
            unit_lim = now_ff;
            if (!unit_gt) begin
               active_in[pad_ff] = 1'b1;
               trig_in[pad_ff]   = now_ff;
               change_in[pad_ff] = now_ff;
            end
            // type timer moves even when the pad itself is refused
            if (is_don) begin
               don_hit_in = now_ff;
            end else begin
               ka_hit_in = now_ff;
            end
            if (pad_ff == PAD_IDX_W'(NUM_PADS - 1)) begin
               state_in = ST_ROLL;
            end else begin
               state_in = ST_KEY;
               pad_in   = pad_ff + PAD_IDX_W'(1);
            end
         end
         ST_ROLL: begin
            unit_b   = roll_hit_ff;
            unit_lim = roll_to_ff;
            if (unit_gt) begin
               if (running_ff > COUNT_BITS'(1)) begin
                  roll_prev_in = running_ff;
               end
               running_in = '0;
            end
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (new_edges != '0) begin
                  roll_hit_in = now_ff;
               end
               running_in   = count_next;
               prev_hits_in = active_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({OUT_COUNT_W'(roll_prev_ff), OUT_COUNT_W'(count_next),
                                      active_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         don_hit_ff   <= '0;
         ka_hit_ff    <= '0;
         roll_hit_ff  <= '0;
         running_ff   <= '0;
         roll_prev_ff <= '0;
         prev_hits_ff <= '0;
         for (int i = 0; i < NUM_PADS; i++) begin
            prev_ff[i]   <= '0;
            trig_ff[i]   <= '0;
            change_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         don_hit_ff   <= don_hit_in;
         ka_hit_ff    <= ka_hit_in;
         roll_hit_ff  <= roll_hit_in;
         running_ff   <= running_in;
         roll_prev_ff <= roll_prev_in;
         prev_hits_ff <= prev_hits_in;
         prev_ff      <= prev_in;
         trig_ff      <= trig_in;
         change_ff    <= change_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         don_deb_ff <= '0;
         ka_deb_ff  <= '0;
         xtalk_ff   <= '0;
         roll_to_ff <= '0;
         thr_ff     <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_KEY_TIMEOUT:  key_ff     <= csr_wdata[DUR_W-1:0];
            REG_DON_DEBOUNCE: don_deb_ff <= csr_wdata[DUR_W-1:0];
            REG_KA_DEBOUNCE:  ka_deb_ff  <= csr_wdata[DUR_W-1:0];
            REG_CROSSTALK:    xtalk_ff   <= csr_wdata[DUR_W-1:0];
            REG_ROLL_TIMEOUT: roll_to_ff <= csr_wdata[TIME_W-1:0];
            REG_THRESHOLDS:   thr_ff     <= csr_wdata[4*DUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < NUM_PADS; i++) begin
            sample_ff[i] <= SAMPLE_BITS'(req_tdata[i*FIELD_SAMPLE_W +: FIELD_SAMPLE_W]);
         end
         now_ff <= req_tdata[NUM_PADS*FIELD_SAMPLE_W +: TIME_W];
      end
   end

`ifndef SYNTHESIS
   a_start_first_pad: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_KEY && pad_ff == '0))
      else $error("scan did not start at the first pad");

   a_chg_after_xtalk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHG) |-> ($past(state_ff) == ST_XTALK))
      else $error("last-change check reached without crosstalk check");

   a_edge_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDGE && (!rsp_valid_ff || rsp_tready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("edge step did not deliver a word");

   a_roll_prev_long: assert property (@(posedge clock) disable iff (reset)
      !$stable(roll_prev_ff) |-> (roll_prev_ff > COUNT_BITS'(1)))
      else $error("previous roll updated with a short roll");
`endif

endmodule
`default_nettype wire
